// ===== design/rvf_pkg.sv =====
// Shared types, constants and helper functions of the row versus frame width selector.
package rvf_pkg;

    // Clamp limits of the geometry registers
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_ROWS  = 4096;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GEOM_W   = 13;
    localparam int BITS_W   = 5;
    localparam int COST_W   = 29;
    localparam int AREA_W   = 2 * GEOM_W;
    localparam int CFG_IDX_W = 2;

    // Geometry reset value
    localparam logic [GEOM_W-1:0] GEOM_RESET = 13'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;

    // Result kinds
    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Saturation ceiling of both costs
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] lowest;
        logic [SAMPLE_W-1:0] spread;
        logic [BITS_W-1:0]   width_bits;
        logic                per_row_better;
        logic [COST_W-1:0]   frame_cost;
        logic [COST_W-1:0]   per_row_cost;
        logic                last;
    } t_result;

    // Words pushed into the result queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        t_result    w0;
        t_result    w1;
    } t_push;

    // Bit length of a 16-bit value, zero for zero
    function automatic logic [BITS_W-1:0] bit_length(input logic [SAMPLE_W-1:0] v);
        logic [BITS_W-1:0] n;
        n = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (v[i]) begin
                n = BITS_W'(i + 1);
            end
        end
        return n;
    endfunction

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v,
                                                     input int top);
        logic [GEOM_W-1:0] r;
        if (v == '0) begin
            r = GEOM_W'(1);
        end else if (32'(v) > top) begin
            r = GEOM_W'(top);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/row_vs_frame_bit_width_selector.sv =====
// Top level of the row versus frame bit-width selector: ports, input and geometry registers.
//
// Takes one 16-bit sample per clock in row order and reports, for each row,
// its minimum, spread and spread bit length; after the last row of a frame a
// decision word follows with the frame statistics, both costs and the
// per-row choice. A sample is held in an input register; combinational
// min/max, bit-length and cost logic then writes its results into a
// four-word queue that drives the output port. A sample enters processing
// only when the queue holds at most two words. The queue drains one word per
// cycle, so the input runs at one sample per cycle while rows span at least
// two samples and the output is not stalled; with one-sample rows every frame
// end adds a decision word and the input slows to the output's one word per
// cycle, as it does under output stall. Geometry writes through the
// configuration port (always ready) take full effect once the geometry
// register and then the registered frame sample count used by the decision
// have been updated.
module row_vs_frame_bit_width_selector #(
    parameter int MAX_WIDTH = rvf_pkg::MAX_WIDTH,
    parameter int MAX_ROWS  = rvf_pkg::MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rvf_pkg::SAMPLE_W-1:0]        i_sample,
    // Result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [rvf_pkg::SAMPLE_W-1:0]        o_lowest,
    output logic [rvf_pkg::SAMPLE_W-1:0]        o_spread,
    output logic [rvf_pkg::BITS_W-1:0]          o_width_bits,
    output logic                                o_per_row_better,
    output logic [rvf_pkg::COST_W-1:0]          o_frame_cost,
    output logic [rvf_pkg::COST_W-1:0]          o_per_row_cost,
    output logic                                o_last,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rvf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rvf_pkg::GEOM_W-1:0]          i_cfg_data
);

    logic                           r_in_vld;
    logic [rvf_pkg::SAMPLE_W-1:0]   r_in_sample;
    logic [rvf_pkg::GEOM_W-1:0]     r_row_width, r_row_count;
    logic [rvf_pkg::AREA_W-1:0]     r_area;
    logic [rvf_pkg::GEOM_W-1:0]     w_cl, h_cl;
    logic                           accept, go, room;
    rvf_pkg::t_push                 push;
    rvf_pkg::t_result               head;

    // Input word handshake
    assign go      = r_in_vld && room;
    assign o_stall = r_in_vld && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sample <= i_sample;
        end
    end

    // Geometry registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= rvf_pkg::GEOM_RESET;
            r_row_count <= rvf_pkg::GEOM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rvf_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                rvf_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry and frame sample count
    assign w_cl = rvf_pkg::clamp_geom(r_row_width, MAX_WIDTH);
    assign h_cl = rvf_pkg::clamp_geom(r_row_count, MAX_ROWS);

    always_ff @(posedge i_clk) begin
        r_area <= rvf_pkg::AREA_W'(w_cl) * rvf_pkg::AREA_W'(h_cl);
    end

    rvf_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_sample (r_in_sample),
        .i_w      (w_cl),
        .i_h      (h_cl),
        .i_area   (r_area),
        .o_push   (push)
    );

    rvf_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_head   (head),
        .o_room   (room)
    );

    // Result word fields
    assign o_kind           = head.kind;
    assign o_lowest         = head.lowest;
    assign o_spread         = head.spread;
    assign o_width_bits     = head.width_bits;
    assign o_per_row_better = head.per_row_better;
    assign o_frame_cost     = head.frame_cost;
    assign o_per_row_cost   = head.per_row_cost;
    assign o_last           = head.last;

endmodule

// ===== design/rvf_result_fifo.sv =====
// Four-word result queue between the statistics stage and the output port.
module rvf_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rvf_pkg::t_push       i_push,
    input  logic                 i_stall,
    output logic                 o_valid,
    output rvf_pkg::t_result     o_head,
    output logic                 o_room
);

    rvf_pkg::t_result                     r_mem [rvf_pkg::FIFO_DEPTH];
    logic [rvf_pkg::FIFO_PTR_W-1:0]       r_wr;
    logic [rvf_pkg::FIFO_PTR_W-1:0]       r_rd;
    logic [rvf_pkg::FIFO_CNT_W-1:0]       r_count;
    logic [rvf_pkg::FIFO_PTR_W-1:0]       n_wr;
    logic [rvf_pkg::FIFO_PTR_W-1:0]       n_rd;
    logic [rvf_pkg::FIFO_CNT_W-1:0]       n_count;
    logic [rvf_pkg::FIFO_PTR_W-1:0]       wr_next;
    logic                                 pop;

    // Head word drives the port
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    // Room for a full frame-end pair
    assign o_room  = (r_count <= rvf_pkg::FIFO_CNT_W'(rvf_pkg::FIFO_DEPTH - 2));
    assign wr_next = r_wr + rvf_pkg::FIFO_PTR_W'(1);

    // Pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + rvf_pkg::FIFO_PTR_W'(i_push.n);
        n_rd    = pop ? r_rd + rvf_pkg::FIFO_PTR_W'(1) : r_rd;
        n_count = r_count + rvf_pkg::FIFO_CNT_W'(i_push.n)
                  - rvf_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage: row summary first, decision behind it
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_next] <= i_push.w1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rvf_pkg::FIFO_CNT_W'(rvf_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_room)
        else $error("push into queue without room for a pair");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == 2'd2) |-> (i_push.w0.kind == rvf_pkg::KIND_ROW &&
                                i_push.w1.kind == rvf_pkg::KIND_FRAME &&
                                i_push.w1.last && !i_push.w0.last))
        else $error("frame-end pair malformed");

endmodule

// ===== design/rvf_stats.sv =====
// Row and frame minimum/maximum tracking, width selection and cost accumulation.
module rvf_stats (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [rvf_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic [rvf_pkg::GEOM_W-1:0]        i_w,
    input  logic [rvf_pkg::GEOM_W-1:0]        i_h,
    input  logic [rvf_pkg::AREA_W-1:0]        i_area,
    output rvf_pkg::t_push                    o_push
);

    logic [rvf_pkg::SAMPLE_W-1:0] r_row_low, r_row_high, r_frame_low, r_frame_high;
    logic [rvf_pkg::GEOM_W-1:0]   r_col, r_row;
    logic [rvf_pkg::COST_W-1:0]   r_cost;

    logic [rvf_pkg::SAMPLE_W-1:0] row_low, row_high, frame_low, frame_high;
    logic [rvf_pkg::SAMPLE_W-1:0] rspread, fspread;
    logic [rvf_pkg::BITS_W-1:0]   rbits, cbits, fbits;
    logic                         row_end, frame_done;
    logic [rvf_pkg::BITS_W+rvf_pkg::GEOM_W-1:0]   row_cost;
    logic [rvf_pkg::COST_W:0]                     cost_sum;
    logic [rvf_pkg::COST_W-1:0]                   rcost, fcost;
    logic [rvf_pkg::BITS_W+rvf_pkg::AREA_W-1:0]   fprod;

    // Running extremes including this sample
    always_comb begin
        row_low    = (i_sample < r_row_low)    ? i_sample : r_row_low;
        row_high   = (i_sample > r_row_high)   ? i_sample : r_row_high;
        frame_low  = (i_sample < r_frame_low)  ? i_sample : r_frame_low;
        frame_high = (i_sample > r_frame_high) ? i_sample : r_frame_high;
    end

    // Row and frame close
    assign row_end    = ({1'b0, r_col} + 14'd1) >= {1'b0, i_w};
    assign frame_done = ({1'b0, r_row} + 14'd1) >= {1'b0, i_h};

    // Row width and its cost, clamped to at least one bit
    assign rspread  = row_high - row_low;
    assign rbits    = rvf_pkg::bit_length(rspread);
    assign cbits    = (rbits == '0) ? rvf_pkg::BITS_W'(1) : rbits;
    assign row_cost = (rvf_pkg::BITS_W+rvf_pkg::GEOM_W)'(cbits)
                      * (rvf_pkg::BITS_W+rvf_pkg::GEOM_W)'(i_w);
    assign cost_sum = {1'b0, r_cost} + (rvf_pkg::COST_W+1)'(row_cost);
    assign rcost    = cost_sum[rvf_pkg::COST_W] ? rvf_pkg::COST_MAX
                                                : cost_sum[rvf_pkg::COST_W-1:0];

    // Frame width and cost, unclamped bits times the sample count
    assign fspread = frame_high - frame_low;
    assign fbits   = rvf_pkg::bit_length(fspread);
    assign fprod   = (rvf_pkg::BITS_W+rvf_pkg::AREA_W)'(fbits)
                     * (rvf_pkg::BITS_W+rvf_pkg::AREA_W)'(i_area);
    assign fcost   = (fprod > (rvf_pkg::BITS_W+rvf_pkg::AREA_W)'(rvf_pkg::COST_MAX))
                     ? rvf_pkg::COST_MAX : fprod[rvf_pkg::COST_W-1:0];

    // Result words
    always_comb begin
        o_push.n                 = 2'd0;
        if (i_go && row_end) begin
            o_push.n = frame_done ? 2'd2 : 2'd1;
        end
        o_push.w0.kind           = rvf_pkg::KIND_ROW;
        o_push.w0.lowest         = row_low;
        o_push.w0.spread         = rspread;
        o_push.w0.width_bits     = rbits;
        o_push.w0.per_row_better = 1'b0;
        o_push.w0.frame_cost     = '0;
        o_push.w0.per_row_cost   = '0;
        o_push.w0.last           = !frame_done;
        o_push.w1.kind           = rvf_pkg::KIND_FRAME;
        o_push.w1.lowest         = frame_low;
        o_push.w1.spread         = fspread;
        o_push.w1.width_bits     = fbits;
        o_push.w1.per_row_better = !(fcost < rcost);
        o_push.w1.frame_cost     = fcost;
        o_push.w1.per_row_cost   = rcost;
        o_push.w1.last           = 1'b1;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_low    <= '1;
            r_row_high   <= '0;
            r_frame_low  <= '1;
            r_frame_high <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_cost       <= '0;
        end else if (i_go) begin
            if (!row_end) begin
                r_row_low    <= row_low;
                r_row_high   <= row_high;
                r_frame_low  <= frame_low;
                r_frame_high <= frame_high;
                r_col        <= r_col + rvf_pkg::GEOM_W'(1);
            end else if (!frame_done) begin
                r_row_low    <= '1;
                r_row_high   <= '0;
                r_frame_low  <= frame_low;
                r_frame_high <= frame_high;
                r_col        <= '0;
                r_row        <= r_row + rvf_pkg::GEOM_W'(1);
                r_cost       <= rcost;
            end else begin
                r_row_low    <= '1;
                r_row_high   <= '0;
                r_frame_low  <= '1;
                r_frame_high <= '0;
                r_col        <= '0;
                r_row        <= '0;
                r_cost       <= '0;
            end
        end
    end

    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && row_end) |=> (r_col == '0 && r_row_low == '1 && r_row_high == '0))
        else $error("row statistics not restarted after row end");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && row_end && frame_done) |=> (r_row == '0 && r_cost == '0))
        else $error("frame state not restarted after decision");

endmodule

// ===== test/row_vs_frame_bit_width_selector_test.sv =====
// Self-checking testbench of the row versus frame bit-width selector.
module row_vs_frame_bit_width_selector_test;

    // Register indexes that the block does not decode
    localparam logic [rvf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rvf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int SETTLE    = 8;     // quiet cycles around geometry writes
    localparam int LONG_HOLD = 120;   // one long output stall
    localparam int RAND_PHASES = 15;

    // Running prediction of row summaries and frame decisions
    class width_scoreboard;
        logic [rvf_pkg::GEOM_W-1:0]   width_reg;
        logic [rvf_pkg::GEOM_W-1:0]   rows_reg;
        logic [rvf_pkg::SAMPLE_W-1:0] row_lo, row_hi, frame_lo, frame_hi;
        int unsigned                  column, row;
        longint unsigned              row_cost;
        rvf_pkg::t_result             expected_q[$];
        int unsigned                  fails;

        function new();
            width_reg = rvf_pkg::GEOM_RESET;
            rows_reg  = rvf_pkg::GEOM_RESET;
            row_lo    = '1;
            row_hi    = '0;
            frame_lo  = '1;
            frame_hi  = '0;
            column    = 0;
            row       = 0;
            row_cost  = 0;
            fails     = 0;
        endfunction

        function int unsigned spread_bits(logic [rvf_pkg::SAMPLE_W-1:0] v);
            int unsigned n;
            n = 0;
            for (int i = 0; i < rvf_pkg::SAMPLE_W; i++) begin
                if (v[i]) n = i + 1;
            end
            return n;
        endfunction

        // Zero counts as one, oversize counts as the limit
        function longint unsigned effective(logic [rvf_pkg::GEOM_W-1:0] v,
                                            int unsigned top);
            if (v == '0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function longint unsigned saturate(longint unsigned v);
            return (v > longint'(rvf_pkg::COST_MAX)) ? longint'(rvf_pkg::COST_MAX) : v;
        endfunction

        function void write_reg(logic [rvf_pkg::CFG_IDX_W-1:0] idx,
                                logic [rvf_pkg::GEOM_W-1:0] data);
            case (idx)
                rvf_pkg::CFG_ROW_WIDTH: width_reg = data;
                rvf_pkg::CFG_ROW_COUNT: rows_reg  = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [rvf_pkg::SAMPLE_W-1:0] s);
            longint unsigned              w, h, fcost;
            logic [rvf_pkg::SAMPLE_W-1:0] rspread, fspread;
            int unsigned                  rbits, cbits, fbits;
            bit                           frame_done;
            rvf_pkg::t_result             r;
            w = effective(width_reg, rvf_pkg::MAX_WIDTH);
            h = effective(rows_reg, rvf_pkg::MAX_ROWS);
            if (s < row_lo)   row_lo   = s;
            if (s > row_hi)   row_hi   = s;
            if (s < frame_lo) frame_lo = s;
            if (s > frame_hi) frame_hi = s;
            if (column + 1 < w) begin
                column++;
                return;
            end
            // row closes
            rspread    = row_hi - row_lo;
            rbits      = spread_bits(rspread);
            cbits      = (rbits == 0) ? 1 : rbits;
            row_cost   = saturate(row_cost + cbits * w);
            frame_done = (row + 1 >= h);
            r            = '0;
            r.kind       = rvf_pkg::KIND_ROW;
            r.lowest     = row_lo;
            r.spread     = rspread;
            r.width_bits = rvf_pkg::BITS_W'(rbits);
            r.last       = !frame_done;
            expected_q.push_back(r);
            column = 0;
            row_lo = '1;
            row_hi = '0;
            if (!frame_done) begin
                row++;
                return;
            end
            // frame closes: decision word
            fspread          = frame_hi - frame_lo;
            fbits            = spread_bits(fspread);
            fcost            = saturate(fbits * w * h);
            r                = '0;
            r.kind           = rvf_pkg::KIND_FRAME;
            r.lowest         = frame_lo;
            r.spread         = fspread;
            r.width_bits     = rvf_pkg::BITS_W'(fbits);
            r.per_row_better = (fcost >= row_cost);
            r.frame_cost     = rvf_pkg::COST_W'(fcost);
            r.per_row_cost   = rvf_pkg::COST_W'(row_cost);
            r.last           = 1'b1;
            expected_q.push_back(r);
            frame_lo = '1;
            frame_hi = '0;
            row      = 0;
            row_cost = 0;
        endfunction

        function void compare_field(string name, longint unsigned exp, longint unsigned got);
            if (exp != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, got);
                fails++;
            end
        endfunction

        function void check_result(rvf_pkg::t_result got);
            rvf_pkg::t_result exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, got);
                fails++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("kind", exp.kind, got.kind);
            compare_field("lowest", exp.lowest, got.lowest);
            compare_field("spread", exp.spread, got.spread);
            compare_field("width_bits", exp.width_bits, got.width_bits);
            compare_field("per_row_better", exp.per_row_better, got.per_row_better);
            compare_field("frame_cost", exp.frame_cost, got.frame_cost);
            compare_field("per_row_cost", exp.per_row_cost, got.per_row_cost);
            compare_field("last", exp.last, got.last);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [rvf_pkg::SAMPLE_W-1:0]  i_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_kind;
    logic [rvf_pkg::SAMPLE_W-1:0]  o_lowest;
    logic [rvf_pkg::SAMPLE_W-1:0]  o_spread;
    logic [rvf_pkg::BITS_W-1:0]    o_width_bits;
    logic                          o_per_row_better;
    logic [rvf_pkg::COST_W-1:0]    o_frame_cost;
    logic [rvf_pkg::COST_W-1:0]    o_per_row_cost;
    logic                          o_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [rvf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rvf_pkg::GEOM_W-1:0]    i_cfg_data = '0;

    rvf_pkg::t_result seen;
    width_scoreboard  sb = new();

    // Sample shaping state, chosen per frame and per row
    int unsigned                  frame_mode = 0;
    logic [rvf_pkg::SAMPLE_W-1:0] frame_value = '0;
    logic [rvf_pkg::SAMPLE_W-1:0] row_base = '0;
    int unsigned                  row_span = 0;
    int unsigned                  burst_left = 0;

    // Receiver state
    bit          hold_want = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_tick = 0;

    assign seen = {o_kind, o_lowest, o_spread, o_width_bits, o_per_row_better,
                   o_frame_cost, o_per_row_cost, o_last};

    row_vs_frame_bit_width_selector u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_lowest         (o_lowest),
        .o_spread         (o_spread),
        .o_width_bits     (o_width_bits),
        .o_per_row_better (o_per_row_better),
        .o_frame_cost     (o_frame_cost),
        .o_per_row_cost   (o_per_row_cost),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: check each accepted word, then pick the next stall
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) sb.check_result(seen);
        if (hold_want && !hold_done) begin
            // one long hold-off so the block backs up onto its input
            i_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles == LONG_HOLD) hold_done = 1'b1;
        end else begin
            if (stall_tick % 32 == 0) stall_mode = $urandom_range(0, 2);
            stall_tick++;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Next sample: constant, narrow per row, full random or rail-to-rail frames
    function logic [rvf_pkg::SAMPLE_W-1:0] next_sample();
        logic [rvf_pkg::SAMPLE_W-1:0] mask;
        logic [rvf_pkg::SAMPLE_W-1:0] r;
        if (sb.column == 0) begin
            if (sb.row == 0) begin
                frame_mode  = $urandom_range(0, 3);
                frame_value = rvf_pkg::SAMPLE_W'($urandom);
            end
            row_base = rvf_pkg::SAMPLE_W'($urandom);
            row_span = $urandom_range(0, rvf_pkg::SAMPLE_W);
        end
        mask = rvf_pkg::SAMPLE_W'((32'd1 << row_span) - 1);
        case (frame_mode)
            0:       r = frame_value;
            1:       r = (row_base & ~mask) | (rvf_pkg::SAMPLE_W'($urandom) & mask);
            2:       r = rvf_pkg::SAMPLE_W'($urandom);
            default: r = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return r;
    endfunction

    // Offer one sample, in bursts with random gaps, and wait for it to go
    task automatic drive_sample(input logic [rvf_pkg::SAMPLE_W-1:0] s);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    task automatic drive_random(input int unsigned count);
        repeat (count) drive_sample(next_sample());
    endtask

    // One register write; valid is left high for a following write
    task automatic cfg_write(input logic [rvf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rvf_pkg::GEOM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_done();
        i_cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [rvf_pkg::GEOM_W-1:0] w,
                                input logic [rvf_pkg::GEOM_W-1:0] h);
        cfg_write(rvf_pkg::CFG_ROW_WIDTH, w);
        cfg_write(rvf_pkg::CFG_ROW_COUNT, h);
        cfg_done();
    endtask

    // Drain: every expected word back, then let a mid-row sample settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly tiny geometry, now and then zero or oversize
    function logic [rvf_pkg::GEOM_W-1:0] pick_geometry();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return rvf_pkg::GEOM_W'($urandom_range(rvf_pkg::MAX_WIDTH + 1, 8191));
        return rvf_pkg::GEOM_W'($urandom_range(1, 6));
    endfunction

    // Stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: a partial row stays open, then one-by-one closes it
        drive_sample('0);
        drive_sample('1);
        drive_random(14);
        drain();
        set_geometry(13'd1, 13'd1);
        drive_sample(16'h0040);
        drain();

        // two by two: full-scale row then a flat row
        set_geometry(13'd2, 13'd2);
        drive_sample(16'h0000);
        drive_sample(16'hFFFF);
        drive_sample(16'h8000);
        drive_sample(16'h8000);
        drain();

        // single-sample frames are flat, so the frame cost wins
        set_geometry(13'd1, 13'd1);
        drive_sample(16'h0001);
        drive_sample(16'hFFFF);
        drain();

        // writes to undecoded indexes change nothing
        cfg_write(CFG_SPARE_A, '1);
        cfg_write(CFG_SPARE_B, 13'h0AAA);
        cfg_done();
        drive_sample(16'h0000);
        drain();

        // zero geometry acts as one
        set_geometry('0, '0);
        drive_sample(16'h5555);
        drive_sample(16'hAAAA);
        drain();

        // four by three with a one-step spread and a flat row, then a mid-frame cut
        set_geometry(13'd4, 13'd3);
        drive_sample(16'h7FFF);
        drive_sample(16'h8000);
        drive_sample(16'h8000);
        drive_sample(16'h7FFF);
        repeat (4) drive_sample(16'h1234);
        drive_sample(16'h0100);
        drive_sample(16'h01FF);
        drain();
        set_geometry(13'd1, 13'd1);
        drive_sample(16'h4321);
        drain();

        // one-sample rows in three-row frames, with a long output hold
        set_geometry(13'd1, 13'd3);
        hold_want <= 1'b1;
        drive_random(120);
        drain();

        // oversize width clamps to the limit, zero rows to one: the row stays open
        set_geometry('1, '0);
        drive_random(30);
        drain();

        // random phases; partial rows and frames carry over between them
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: cfg_write(rvf_pkg::CFG_ROW_WIDTH, pick_geometry());
                1: cfg_write(rvf_pkg::CFG_ROW_COUNT, pick_geometry());
                2: cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                             rvf_pkg::GEOM_W'($urandom));
                default: begin
                    cfg_write(rvf_pkg::CFG_ROW_WIDTH, pick_geometry());
                    cfg_write(rvf_pkg::CFG_ROW_COUNT, pick_geometry());
                end
            endcase
            cfg_done();
            drive_random($urandom_range(20, 40));
            drain();
        end

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("row_vs_frame_bit_width_selector_test OK");
        end else begin
            $display("row_vs_frame_bit_width_selector_test NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("row_vs_frame_bit_width_selector_test NOT OK");
        $finish;
    end

endmodule
